// ===== rtl/bisb_pkg.sv =====
// Shared types and constants of the byte initialization bitmap.
package bisb_pkg;

	localparam int unsigned WindowBytesDefault = 65536;
	localparam int unsigned MaxAccessDefault   = 64;
	localparam int unsigned AddrW  = 48;
	localparam int unsigned CountW = 7;
	localparam int unsigned WordW  = 64;
	localparam int unsigned OffW   = 6;

	localparam logic [1:0] ACT_MARK  = 2'd0;
	localparam logic [1:0] ACT_MASK  = 2'd1;
	localparam logic [1:0] ACT_CHECK = 2'd2;
	localparam logic [1:0] ACT_CLEAR = 2'd3;

	localparam logic [0:0] REG_WINDOW_BASE = 1'b0;

	typedef struct packed {
		logic [1:0]        action;
		logic [AddrW-1:0]  start_addr;
		logic [CountW-1:0] byte_count;
		logic [WordW-1:0]  init_mask;
	} req_t;

	typedef struct packed {
		logic            status;
		logic            has_hole;
		logic [OffW-1:0] low_offset;
		logic [OffW-1:0] high_offset;
		logic            last;
	} rsp_t;

	// Classified request passed from front to back.
	typedef struct packed {
		logic [1:0]        action;
		logic              simple;    // empty or out of window: one result
		logic              err;
		logic [AddrW-1:0]  offset;    // byte offset into window
		logic [WordW-1:0]  range;     // bit i set: byte i in range
		logic [WordW-1:0]  mask;
	} cmd_t;

endpackage

// ===== rtl/bisb_front.sv =====
// Front end: saturate count, window check, build range masks, queue.
module bisb_front #(
	parameter int unsigned WINDOW_BYTES = bisb_pkg::WindowBytesDefault,
	parameter int unsigned MAX_ACCESS   = bisb_pkg::MaxAccessDefault
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [bisb_pkg::AddrW-1:0] window_base,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  bisb_pkg::req_t            in_req,
	output logic                      cmd_valid,
	input  logic                      cmd_ready,
	output bisb_pkg::cmd_t            cmd
);
	localparam int unsigned AW = bisb_pkg::AddrW;
	localparam int unsigned CW = bisb_pkg::CountW;

	// Two-entry queue.
	bisb_pkg::cmd_t    q_q [2];
	logic              wp_q, rp_q;
	logic [1:0]        cnt_q;
	bisb_pkg::cmd_t    c;
	logic [CW-1:0]     count;
	logic [AW:0]       diff, span;
	logic              push, pop;

	always_comb begin
		count = (in_req.byte_count > CW'(MAX_ACCESS)) ? CW'(MAX_ACCESS) : in_req.byte_count;
		diff = {1'b0, in_req.start_addr} - {1'b0, window_base};
		span = {1'b0, diff[AW-1:0]} + (AW+1)'(count);
		c.action = in_req.action;
		c.offset = diff[AW-1:0];
		c.err = (count != '0) && (diff[AW] || span > (AW+1)'(WINDOW_BYTES));
		c.simple = (count == '0) || c.err;
		c.range = (count >= CW'(64)) ? '1 : ((64'd1 << count[5:0]) - 64'd1);
		c.mask = in_req.init_mask & c.range;
	end

	assign in_ready  = (cnt_q != 2'd2);
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd       = q_q[rp_q];
	assign push      = in_valid && in_ready;
	assign pop       = cmd_valid && cmd_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			q_q[wp_q] <= c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

`ifndef SYNTH
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == 2'd2 |-> !push) else $error("queue overflow");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == 2'd0 |-> !pop) else $error("queue underflow");
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3) else $error("queue count out of range");
`endif
endmodule

// ===== rtl/bisb_back.sv =====
// Back end: clearing pass, word read-modify-write, run extraction.
module bisb_back #(
	parameter int unsigned WINDOW_BYTES = bisb_pkg::WindowBytesDefault
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	output logic           cmd_ready,
	input  bisb_pkg::cmd_t cmd,
	output logic           out_valid,
	input  logic           out_ready,
	output bisb_pkg::rsp_t out_rsp
);
	localparam int unsigned WORDS = (WINDOW_BYTES + 63) / 64;
	localparam int unsigned IW = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam int unsigned AW = bisb_pkg::AddrW;

	localparam logic [2:0] ST_CLR  = 3'd0;
	localparam logic [2:0] ST_IDLE = 3'd1;
	localparam logic [2:0] ST_RD0  = 3'd2;
	localparam logic [2:0] ST_RD1  = 3'd3;
	localparam logic [2:0] ST_WR   = 3'd4;
	localparam logic [2:0] ST_EMIT = 3'd5;

	logic [63:0]  mem [WORDS];
	logic [63:0]  rdata_q;
	logic [2:0]   st_q;
	logic [IW:0]  clr_q;
	bisb_pkg::cmd_t cmd_q;
	logic [IW-1:0] w0_q, w1_q;
	logic [5:0]   sh_q;
	logic [63:0]  lo_q;          // word 0 contents
	logic [127:0] hole_q;        // holes in range for a check, shifted to offset 0; new word pair otherwise
	logic [6:0]   pos_q;         // scan position
	logic         any_q;
	logic         ov_q;
	logic         ov_set;

	// Memory port controls.
	logic          mwe, mre;
	logic [IW-1:0] maddr;
	logic [63:0]   mwd;

	// Write data: combine range bits over two words.
	logic [127:0] pair, rng, val, newp;
	logic [63:0]  w1cur;
	// Run finding over hole vector from pos_q.
	logic [63:0]  hv, fromp, rest, aft;
	logic [6:0]   lo_i, hi_i;
	logic         found, more;

	always_comb begin
		w1cur = rdata_q;
		pair = {w1cur, lo_q};
		rng  = {64'd0, cmd_q.range} << sh_q;
		unique case (cmd_q.action)
			bisb_pkg::ACT_MARK:  val = '1;
			bisb_pkg::ACT_MASK:  val = {64'd0, cmd_q.mask} << sh_q;
			default:             val = '0;
		endcase
		newp = (pair & ~rng) | (val & rng);
	end

	always_comb begin
		hv = hole_q[63:0];
		fromp = hv & ~((64'd1 << pos_q[5:0]) - 64'd1);
		if (pos_q[6]) fromp = '0;
		found = (fromp != '0);
		lo_i = '0;
		for (int i = 63; i >= 0; i--) if (fromp[i]) lo_i = 7'(i);
		rest = ~hv & ~((64'd1 << lo_i[5:0]) - 64'd1);
		hi_i = 7'd63;
		for (int i = 63; i >= 0; i--) if (rest[i]) hi_i = 7'(i - 1);
		aft = (hi_i[5:0] == 6'd63) ? '0 : (hv & ~((64'd2 << hi_i[5:0]) - 64'd1));
		more = (aft != '0);
	end

	assign out_valid = ov_q;
	assign cmd_ready = (st_q == ST_IDLE) && (!ov_q || out_ready);
	// Load a new result: a one-result request taken at idle, or any emit slot.
	assign ov_set = (cmd_valid && cmd_ready && cmd.simple) ||
		((st_q == ST_EMIT) && (!ov_q || out_ready));

	always_comb begin
		mwe = 1'b0; mre = 1'b0; maddr = w0_q; mwd = newp[63:0];
		unique case (st_q)
			ST_CLR: begin
				mwe = 1'b1; maddr = clr_q[IW-1:0]; mwd = '0;
			end
			ST_RD0: begin
				mre = 1'b1; maddr = w0_q;
			end
			ST_RD1: begin
				mre = 1'b1; maddr = w1_q;
			end
			ST_WR: begin
				mwe = (cmd_q.action != bisb_pkg::ACT_CHECK); maddr = w0_q;
			end
			ST_EMIT: begin
				// second word written the cycle after first when it differs
				mwe = any_q && (cmd_q.action != bisb_pkg::ACT_CHECK);
				maddr = w1_q; mwd = hole_q[127:64];
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mwe) mem[maddr] <= mwd;
		if (mre) rdata_q <= mem[maddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_CLR; clr_q <= '0; ov_q <= 1'b0;
			cmd_q <= '0; w0_q <= '0; w1_q <= '0; sh_q <= '0; lo_q <= '0;
			hole_q <= '0; pos_q <= '0; any_q <= 1'b0; out_rsp <= '0;
		end else begin
			ov_q <= ov_set || (ov_q && !out_ready);
			unique case (st_q)
				ST_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == (IW+1)'(WORDS - 1)) st_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (cmd_valid && cmd_ready) begin
						cmd_q <= cmd;
						w0_q <= IW'(cmd.offset[AW-1:6]);
						w1_q <= IW'(cmd.offset[AW-1:6] + 1'b1);
						sh_q <= cmd.offset[5:0];
						if (cmd.simple) begin
							out_rsp <= '{status: cmd.err, has_hole: 1'b0,
								low_offset: '0, high_offset: '0, last: 1'b1};
						end else begin
							st_q <= ST_RD0;
						end
					end
				end
				ST_RD0: st_q <= ST_RD1;
				ST_RD1: begin
					lo_q <= rdata_q;
					st_q <= ST_WR;
				end
				ST_WR: begin
					// rdata_q now holds word 1 (or stale if out of window)
					any_q <= (w1_q != w0_q) && (cmd_q.range[63:0] != '0) &&
						(rng[127:64] != '0);
					hole_q <= (cmd_q.action == bisb_pkg::ACT_CHECK) ?
						({64'd0, cmd_q.range} & ~(pair >> sh_q)) : newp;
					pos_q <= '0;
					st_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (cmd_q.action != bisb_pkg::ACT_CHECK) begin
						if (!ov_q || out_ready) begin
							out_rsp <= '{status: 1'b0, has_hole: 1'b0,
								low_offset: '0, high_offset: '0, last: 1'b1};
							st_q <= ST_IDLE;
						end
						any_q <= 1'b0;
					end else if (!ov_q || out_ready) begin
						if (!found) begin
							out_rsp <= '{status: 1'b0, has_hole: 1'b0,
								low_offset: '0, high_offset: '0, last: 1'b1};
							st_q <= ST_IDLE;
						end else begin
							out_rsp <= '{status: 1'b0, has_hole: 1'b1,
								low_offset: lo_i[5:0], high_offset: hi_i[5:0],
								last: !more};
							pos_q <= hi_i + 7'd2;
							if (!more) st_q <= ST_IDLE;
						end
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

`ifndef SYNTH
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_valid && cmd_ready) |-> st_q == ST_IDLE) else $error("accept while busy");
	a_hold_out: assert property (@(posedge clk) disable iff (!arst_n)
		(ov_q && !out_ready) |=> ov_q && $stable(out_rsp)) else $error("result dropped");
	a_clean_no_hole: assert property (@(posedge clk) disable iff (!arst_n)
		(ov_q && out_rsp.status) |-> !out_rsp.has_hole && out_rsp.last)
		else $error("error result with run");
`endif
endmodule

// ===== rtl/byte_init_shadow_bitmap.sv =====
// Top level of the byte initialization bitmap.
// Empty or out-of-window requests pass the front queue and are answered from the output
// register; window requests step through RD0, RD1, WR and EMIT, then give one run per cycle while the output is free.
// Window requests are taken one at a time, paced by the single memory port (two word reads,
// up to two writes); other requests pass one per cycle while the back end is idle and the output is free.
// Reset: clears control and window_base at once, then a clearing pass zeroes the bitmap.
module byte_init_shadow_bitmap #(
	parameter int unsigned WINDOW_BYTES = bisb_pkg::WindowBytesDefault,
	parameter int unsigned MAX_ACCESS   = bisb_pkg::MaxAccessDefault
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            psel,
	input  logic            penable,
	input  logic            pwrite,
	input  logic [3:0]      paddr,
	input  logic [63:0]     pwdata,
	output logic [63:0]     prdata,
	output logic            pready,
	input  logic            in_valid,
	output logic            in_ready,
	input  bisb_pkg::req_t  in_req,
	output logic            out_valid,
	input  logic            out_ready,
	output bisb_pkg::rsp_t  out_rsp
);
	logic [bisb_pkg::AddrW-1:0] window_base_q;
	logic           cmd_valid, cmd_ready;
	bisb_pkg::cmd_t cmd;

	assign pready = 1'b1;
	// Hold the window base; registers sit 8 bytes apart.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_base_q <= '0;
		end else if (psel && penable && pwrite &&
				paddr == {bisb_pkg::REG_WINDOW_BASE, 3'd0}) begin
			window_base_q <= pwdata[bisb_pkg::AddrW-1:0];
		end
	end
	assign prdata = (paddr[3] == bisb_pkg::REG_WINDOW_BASE && paddr[2:0] == 3'd0) ?
		{16'd0, window_base_q} : 64'd0;

	bisb_front #(.WINDOW_BYTES(WINDOW_BYTES), .MAX_ACCESS(MAX_ACCESS)) u_front (
		.clk, .arst_n, .window_base(window_base_q), .in_valid, .in_ready, .in_req,
		.cmd_valid, .cmd_ready, .cmd);

	bisb_back #(.WINDOW_BYTES(WINDOW_BYTES)) u_back (
		.clk, .arst_n, .cmd_valid, .cmd_ready, .cmd, .out_valid, .out_ready, .out_rsp);
endmodule

// ===== tb/byte_init_shadow_bitmap_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the byte initialization bitmap.
module byte_init_shadow_bitmap_tb;

	localparam int unsigned WinBytes = bisb_pkg::WindowBytesDefault;
	localparam int unsigned Words    = WinBytes / 64;
	localparam int unsigned WordIdxW = $clog2(Words);
	localparam int unsigned MaxAcc   = bisb_pkg::MaxAccessDefault;
	localparam int unsigned CycleLimit = 2000000;
	localparam logic [3:0] AddrWindowBase = {bisb_pkg::REG_WINDOW_BASE, 3'd0};

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [63:0] pwdata;
	logic [63:0] prdata;
	logic        pready;
	logic        in_valid;
	logic        in_ready;
	bisb_pkg::req_t in_req;
	logic        out_valid;
	logic        out_ready;
	bisb_pkg::rsp_t out_rsp;

	byte_init_shadow_bitmap u_dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_ready(in_ready), .in_req(in_req),
		.out_valid(out_valid), .out_ready(out_ready), .out_rsp(out_rsp)
	);

	// Shadow copy of the bitmap, updated on every accepted request, and of the window base, set on each register write.
	logic [63:0] shadow_bits [Words];
	logic [bisb_pkg::AddrW-1:0] shadow_base;
	bisb_pkg::rsp_t expected_rsps [$];

	int unsigned fail_count;
	int unsigned cycle_count;
	int unsigned send_idle_pct;
	int unsigned recv_idle_pct;
	bit          hold_off_recv;

	initial clk = 1'b0;
	always #10 clk = ~clk;

	function automatic bit shadow_get(input longint unsigned p);
		return shadow_bits[WordIdxW'(p >> 6)][p[5:0]];
	endfunction

	task automatic shadow_put(input longint unsigned p, input bit v);
		shadow_bits[WordIdxW'(p >> 6)][p[5:0]] = v;
	endtask

	// Append one result to the expectation queue.
	task automatic queue_rsp(input bisb_pkg::rsp_t rsp);
		expected_rsps.insert(expected_rsps.size(), rsp);
	endtask

	// Work out the results of one request and update the shadow bitmap.
	task automatic predict_request(input bisb_pkg::req_t r);
		int unsigned cnt;
		longint unsigned off;
		int unsigned i;
		bit in_run;
		bit hole;
		int unsigned run_lo;
		int n;
		bisb_pkg::rsp_t rsp;
		cnt = (r.byte_count > MaxAcc) ? MaxAcc : r.byte_count;
		rsp = '0;
		rsp.last = 1'b1;
		if (cnt == 0) begin
			queue_rsp(rsp);
			return;
		end
		if (r.start_addr < shadow_base ||
				64'(r.start_addr - shadow_base) + 64'(cnt) > 64'(WinBytes)) begin
			rsp.status = 1'b1;
			queue_rsp(rsp);
			return;
		end
		off = 64'(r.start_addr - shadow_base);
		if (r.action == bisb_pkg::ACT_CHECK) begin
			in_run = 1'b0;
			run_lo = 0;
			n = 0;
			for (i = 0; i <= cnt; i++) begin
				hole = (i < cnt) && !shadow_get(off + i);
				if (hole && !in_run) begin
					in_run = 1'b1;
					run_lo = i;
				end else if (!hole && in_run) begin
					in_run = 1'b0;
					rsp = '0;
					rsp.has_hole = 1'b1;
					rsp.low_offset = bisb_pkg::OffW'(run_lo);
					rsp.high_offset = bisb_pkg::OffW'(i - 1);
					queue_rsp(rsp);
					n++;
				end
			end
			if (n == 0) begin
				rsp = '0;
				rsp.last = 1'b1;
				queue_rsp(rsp);
			end else begin
				expected_rsps[expected_rsps.size() - 1].last = 1'b1;
			end
			return;
		end
		for (i = 0; i < cnt; i++) begin
			case (r.action)
				bisb_pkg::ACT_MARK: shadow_put(off + i, 1'b1);
				bisb_pkg::ACT_MASK: shadow_put(off + i, r.init_mask[i]);
				default:            shadow_put(off + i, 1'b0);
			endcase
		end
		queue_rsp(rsp);
	endtask

	// Compare each accepted result against the oldest expectation.
	always @(posedge clk) begin
		bisb_pkg::rsp_t exp_rsp;
		if (arst_n && out_valid && out_ready) begin
			if (expected_rsps.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual %h", $time, out_rsp);
				fail_count++;
			end else begin
				exp_rsp = expected_rsps.pop_front();
				if (out_rsp !== exp_rsp) begin
					$display("%0t: result mismatch, expected %h, actual %h",
						$time, exp_rsp, out_rsp);
					fail_count++;
				end
			end
		end
	end

	// Drive the receiver: random stalls, or a long hold-off when asked.
	always @(posedge clk) begin
		if (!arst_n)
			out_ready <= 1'b0;
		else if (hold_off_recv)
			out_ready <= 1'b0;
		else
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// Abort a hung run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CycleLimit) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// Write a register through a setup and access phase.
	task automatic write_reg(input logic [3:0] addr, input logic [63:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		shadow_base = data[bisb_pkg::AddrW-1:0];
	endtask

	// Offer one request, holding it until accepted, then predict it.
	task automatic send_request(input bisb_pkg::req_t r);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_req   <= r;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		predict_request(r);
	endtask

	// Drop the request, wait until every expected result is back, let the tail drain.
	task automatic drain;
		in_valid <= 1'b0;
		while (expected_rsps.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	// Build a random request; most land inside the window near a few hot spots.
	function automatic bisb_pkg::req_t random_request();
		bisb_pkg::req_t r;
		int unsigned sel;
		r.action = 2'($urandom_range(3));
		r.init_mask = {$urandom(), $urandom()};
		sel = $urandom_range(99);
		if (sel < 5)
			r.byte_count = 7'($urandom_range(127));
		else
			r.byte_count = 7'($urandom_range(MaxAcc, 1));
		if (sel < 10)
			r.start_addr = 48'({$urandom(), $urandom()});
		else if (sel < 15)
			r.start_addr = shadow_base + WinBytes - $urandom_range(70);
		else
			r.start_addr = shadow_base + $urandom_range(511) + 64 * $urandom_range(3) * 200;
		return r;
	endfunction

	typedef struct {
		bisb_pkg::req_t r;
		bit             typed;
		bisb_pkg::rsp_t rsp;
	} stim_row_t;

	stim_row_t directed [$];

	// Append one row to the directed table.
	task automatic add_row(input bisb_pkg::req_t r, input bit typed,
			input bisb_pkg::rsp_t rsp);
		stim_row_t row;
		row.r = r;
		row.typed = typed;
		row.rsp = rsp;
		directed.insert(directed.size(), row);
	endtask

	function automatic bisb_pkg::req_t mk(input logic [1:0] a,
			input logic [bisb_pkg::AddrW-1:0] s,
			input logic [bisb_pkg::CountW-1:0] c, input logic [63:0] m);
		bisb_pkg::req_t r;
		r.action = a;
		r.start_addr = s;
		r.byte_count = c;
		r.init_mask = m;
		return r;
	endfunction

	initial begin
		bisb_pkg::rsp_t ok_rsp;
		bisb_pkg::rsp_t err_rsp;
		bisb_pkg::rsp_t hole_all;
		int unsigned k;
		int unsigned phase;
		logic [bisb_pkg::AddrW-1:0] bases [4];
		ok_rsp = '0;
		ok_rsp.last = 1'b1;
		err_rsp = ok_rsp;
		err_rsp.status = 1'b1;
		hole_all = '0;
		hole_all.has_hole = 1'b1;
		hole_all.high_offset = 6'd63;
		hole_all.last = 1'b1;

		fail_count = 0;
		cycle_count = 0;
		hold_off_recv = 1'b0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		in_req = '0;
		shadow_base = '0;
		foreach (shadow_bits[w])
			shadow_bits[w] = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table: after reset everything is uninitialized.
		add_row(mk(bisb_pkg::ACT_CHECK, 48'd0, 7'd64, '0), 1'b1, hole_all);
		add_row(mk(bisb_pkg::ACT_MARK, 48'd0, 7'd0, '0), 1'b1, ok_rsp);
		add_row(mk(bisb_pkg::ACT_MARK, 48'd0, 7'd64, '0), 1'b1, ok_rsp);
		add_row(mk(bisb_pkg::ACT_CHECK, 48'd0, 7'd64, '0), 1'b1, ok_rsp);
		add_row(mk(bisb_pkg::ACT_MASK, 48'd0, 7'd64, 64'h5555_5555_5555_5555), 1'b1, ok_rsp);
		add_row(mk(bisb_pkg::ACT_CHECK, 48'd0, 7'd64, '0), 1'b0, ok_rsp);
		add_row(mk(bisb_pkg::ACT_MASK, 48'd100, 7'd40, '1), 1'b1, ok_rsp);
		add_row(mk(bisb_pkg::ACT_CHECK, 48'd90, 7'd64, '0), 1'b0, ok_rsp);
		add_row(mk(bisb_pkg::ACT_MASK, 48'd200, 7'd8, 64'hFFFF_FFFF_FFFF_FF00), 1'b1, ok_rsp);
		add_row(mk(bisb_pkg::ACT_CHECK, 48'd200, 7'd16, '0), 1'b0, ok_rsp);
		add_row(mk(bisb_pkg::ACT_CLEAR, 48'd10, 7'd5, '0), 1'b1, ok_rsp);
		add_row(mk(bisb_pkg::ACT_CHECK, 48'd0, 7'd127, '0), 1'b0, ok_rsp);
		add_row(mk(bisb_pkg::ACT_MARK, 48'd65472, 7'd64, '0), 1'b1, ok_rsp);
		add_row(mk(bisb_pkg::ACT_CHECK, 48'd65500, 7'd36, '0), 1'b1, ok_rsp);
		add_row(mk(bisb_pkg::ACT_CHECK, 48'd65473, 7'd64, '0), 1'b1, err_rsp);
		add_row(mk(bisb_pkg::ACT_MARK, 48'hFFFF_FFFF_FFFF, 7'd1, '0), 1'b1, err_rsp);
		add_row(mk(bisb_pkg::ACT_MARK, 48'd65536, 7'd1, '0), 1'b1, err_rsp);
		add_row(mk(bisb_pkg::ACT_CHECK, 48'd60, 7'd8, '0), 1'b0, ok_rsp);
		add_row(mk(bisb_pkg::ACT_CHECK, 48'd5, 7'd0, '1), 1'b1, ok_rsp);
		add_row(mk(bisb_pkg::ACT_CLEAR, 48'd0, 7'd64, '0), 1'b1, ok_rsp);
		add_row(mk(bisb_pkg::ACT_CHECK, 48'd0, 7'd64, '0), 1'b1, hole_all);

		foreach (directed[row_idx]) begin
			send_request(directed[row_idx].r);
			if (directed[row_idx].typed && expected_rsps[$] !== directed[row_idx].rsp) begin
				$display("%0t: table row %0d mispredicted, expected %h, actual %h",
					$time, row_idx, directed[row_idx].rsp, expected_rsps[$]);
				fail_count++;
			end
		end
		drain();

		// Random phases across window bases, including both extremes.
		bases[0] = 48'd4096;
		bases[1] = 48'hFFFF_FFFF_FFFF - WinBytes + 1;
		bases[2] = 48'({$urandom(), $urandom()});
		bases[3] = 48'd0;
		for (phase = 0; phase < 4; phase++) begin
			write_reg(AddrWindowBase, 64'(bases[phase]));
			case (phase)
				0: begin
					send_idle_pct = 31;
					recv_idle_pct = 82;
				end
				1: begin
					send_idle_pct = 82;
					recv_idle_pct = 31;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			for (k = 0; k < 72; k++)
				send_request(random_request());
			drain();
		end

		// Hold off the receiver while checks keep arriving, to fill the block.
		fork
			begin
				hold_off_recv = 1'b1;
				repeat (300) @(posedge clk);
				hold_off_recv = 1'b0;
			end
			begin
				for (k = 0; k < 20; k++)
					send_request(mk(bisb_pkg::ACT_CHECK, 48'(64 * k), 7'd64, '0));
			end
		join
		drain();

		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
